@@ rtl/core/wtse_pkg.sv @@
// ----------------------------------------------------------------------------
// wtse_pkg
// types and codes shared by the workload table state engine
// ----------------------------------------------------------------------------
package wtse_pkg;

    typedef enum logic [3:0] {
        OP_ALLOC         = 4'd0,
        OP_ADD_END       = 4'd1,
        OP_REM_BEGIN     = 4'd2,
        OP_REM_END       = 4'd3,
        OP_SCHED_BEGIN   = 4'd4,
        OP_SCHED_END     = 4'd5,
        OP_UNSCHED_BEGIN = 4'd6,
        OP_UNSCHED_END   = 4'd7,
        OP_SIGNAL        = 4'd8,
        OP_QUERY         = 4'd9,
        OP_TRY_WAIT      = 4'd10
    } t_op;

    localparam logic [3:0] ST_FREE         = 4'd0;
    localparam logic [3:0] ST_ADDING       = 4'd1;
    localparam logic [3:0] ST_REMOVING     = 4'd2;
    localparam logic [3:0] ST_SCHEDULING   = 4'd3;
    localparam logic [3:0] ST_READY        = 4'd4;
    localparam logic [3:0] ST_RUNNING      = 4'd5;
    localparam logic [3:0] ST_WAITING      = 4'd6;
    localparam logic [3:0] ST_UNSCHEDULING = 4'd7;
    localparam logic [3:0] ST_FINISHED     = 4'd8;

    localparam logic [2:0] RC_OK    = 3'd0;
    localparam logic [2:0] RC_PARAM = 3'd1;
    localparam logic [2:0] RC_STATE = 3'd2;
    localparam logic [2:0] RC_LIMIT = 3'd3;
    localparam logic [2:0] RC_BUSY  = 3'd4;

    localparam logic [2:0] QK_INIT     = 3'd0;
    localparam logic [2:0] QK_READY    = 3'd1;
    localparam logic [2:0] QK_WAITING  = 3'd2;
    localparam logic [2:0] QK_RUNNING  = 3'd3;
    localparam logic [2:0] QK_FINISHED = 3'd4;
    localparam logic [2:0] QK_SIGNAL   = 3'd5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_ALLOC,
        S_SCAN,
        S_DONE
    } t_fsm;

    typedef struct packed {
        logic [3:0] operation;
        logic [7:0] slot_id;
        logic       cancel;
        logic [7:0] priority_req;
        logic [2:0] query_kind;
    } t_cmd;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  given_id;
        logic        query_answer;
        logic        blk_ready;
        logic        blk_waiting;
        logic [7:0]  block_top_priority;
        logic [31:0] access_count;
    } t_result;

endpackage

@@ rtl/core/workload_table_state_engine.sv @@
// ----------------------------------------------------------------------------
// workload_table_state_engine
// slot table with guarded state transitions, allocation and block rescans
// ----------------------------------------------------------------------------
// One command at a time. busy rises on the cycle after start and the result
// appears with o_done for one cycle. A plain transition, query or try-wait
// passes through S_READ (decode of the slot) and S_DONE before the result.
// Allocation walks the slot memory one slot a cycle from slot 1 of block 0.
// A rescan walks the block's slots through the one memory read port in
// S_SCAN before S_DONE. The slot memory holds a power-of-two row per block
// and is cleared by a pass of one cycle per entry after reset with busy held
// high. The receiver cannot stall: o_done is one cycle wide.
module workload_table_state_engine #(
    parameter int NUM_BLOCKS      = 4,
    parameter int SLOTS_PER_BLOCK = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  wtse_pkg::t_cmd       i_cmd,
    output logic                 o_done,
    output wtse_pkg::t_result    o_result
);
    localparam int TOTAL = NUM_BLOCKS * SLOTS_PER_BLOCK;
    localparam int SW    = (SLOTS_PER_BLOCK > 1) ? $clog2(SLOTS_PER_BLOCK) : 1;
    localparam int BW    = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int DEPTH = NUM_BLOCKS * (1 << SW);
    localparam int AW    = $clog2(DEPTH);
    // reciprocal of the block size, exact for every 8-bit id
    localparam int RECIP = (65536 + SLOTS_PER_BLOCK - 1) / SLOTS_PER_BLOCK;
    localparam logic [AW-1:0] LAST_ADDR =
        AW'(((NUM_BLOCKS - 1) << SW) + SLOTS_PER_BLOCK - 1);

    function automatic logic [7:0] blk_of(input logic [7:0] id);
        logic [23:0] prod;
        prod = 24'(id) * 24'(RECIP);
        return prod[23:16];
    endfunction

    // slot memory: {signal, priority, state}
    logic [12:0] mem [DEPTH];
    logic [12:0] r_rd;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [12:0]   wr_data;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd <= mem[rd_addr];
    end

    logic [NUM_BLOCKS-1:0] r_rdy, n_rdy, r_wt, n_wt;
    logic [7:0]  r_top [NUM_BLOCKS];
    logic [7:0]  n_top_w;
    logic        top_we;
    logic [31:0] r_acc, n_acc;

    wtse_pkg::t_fsm r_fsm, n_fsm;
    wtse_pkg::t_cmd r_cmd, n_cmd;
    logic          r_clr, n_clr;
    logic [AW:0]   r_ptr, n_ptr;      // walk pointer
    logic [AW:0]   r_lag, n_lag;      // address of data now in r_rd
    logic          r_scan_rdy, n_scan_rdy, r_scan_wt, n_scan_wt;
    logic [7:0]    r_scan_top, n_scan_top;
    logic [BW-1:0] r_blk, n_blk;
    logic          r_touch, n_touch;
    logic [2:0]    r_st, n_st;
    logic [7:0]    r_given, n_given;
    logic          r_ans, n_ans;
    logic          r_first, n_first;
    logic          r_done, n_done;

    logic [7:0]    cmd_blk8, cmd_slot8;
    logic [AW-1:0] cmd_addr;
    logic [7:0]    id_blk8, id_slot8;
    logic [AW-1:0] id_addr;
    logic          id_ok;
    logic [3:0]    rd_st;
    logic [AW:0]   scan_last;

    // memory row of a slot id: {block, slot index}
    assign cmd_blk8  = blk_of(i_cmd.slot_id);
    assign cmd_slot8 = i_cmd.slot_id - cmd_blk8 * 8'(SLOTS_PER_BLOCK);
    assign cmd_addr  = AW'({BW'(cmd_blk8), SW'(cmd_slot8)});
    assign id_blk8   = blk_of(r_cmd.slot_id);
    assign id_slot8  = r_cmd.slot_id - id_blk8 * 8'(SLOTS_PER_BLOCK);
    assign id_addr   = AW'({BW'(id_blk8), SW'(id_slot8)});
    assign id_ok   = (32'(r_cmd.slot_id) < 32'(TOTAL))
                  && (id_slot8 != '0);
    assign rd_st   = r_rd[3:0];
    assign scan_last = (AW+1)'({r_blk, {SW{1'b0}}}) + (AW+1)'(SLOTS_PER_BLOCK - 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm <= wtse_pkg::S_IDLE;
            r_clr <= 1'b1;
            r_ptr <= '0;
            r_rdy <= '0;
            r_wt  <= '0;
            r_acc <= '0;
            r_done <= 1'b0;
        end else begin
            r_fsm <= n_fsm;
            r_clr <= n_clr;
            r_ptr <= n_ptr;
            r_rdy <= n_rdy;
            r_wt  <= n_wt;
            r_acc <= n_acc;
            r_done <= n_done;
        end
    end

    // top priority has its own reset so that untouched blocks read zero
    always_ff @(posedge i_clk) begin
        for (int b = 0; b < NUM_BLOCKS; b++) begin
            if (!i_rst_n) begin
                r_top[b] <= '0;
            end else if (top_we && r_blk == BW'(b)) begin
                r_top[b] <= n_top_w;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_lag      <= n_lag;
        r_scan_rdy <= n_scan_rdy;
        r_scan_wt  <= n_scan_wt;
        r_scan_top <= n_scan_top;
        r_blk      <= n_blk;
        r_touch    <= n_touch;
        r_st       <= n_st;
        r_given    <= n_given;
        r_ans      <= n_ans;
        r_first    <= n_first;
    end

    always_comb begin
        n_fsm = r_fsm; n_clr = r_clr; n_ptr = r_ptr; n_rdy = r_rdy; n_wt = r_wt;
        n_acc = r_acc; n_cmd = r_cmd; n_lag = r_ptr; n_scan_rdy = r_scan_rdy;
        n_scan_wt = r_scan_wt; n_scan_top = r_scan_top; n_blk = r_blk;
        n_touch = r_touch; n_st = r_st; n_given = r_given; n_ans = r_ans;
        n_first = 1'b0; n_done = 1'b0;
        top_we = 1'b0; n_top_w = r_scan_top;
        rd_addr = r_ptr[AW-1:0];
        wr_en = 1'b0; wr_addr = r_ptr[AW-1:0]; wr_data = '0;

        unique case (r_fsm)
            wtse_pkg::S_IDLE: begin
                if (r_clr) begin
                    wr_en = 1'b1;
                    n_ptr = r_ptr + 1'b1;
                    if (r_ptr == (AW+1)'(DEPTH - 1)) begin
                        n_clr = 1'b0;
                        n_ptr = '0;
                    end
                end else if (start) begin
                    n_cmd = i_cmd;
                    n_st = wtse_pkg::RC_OK; n_given = '0; n_ans = 1'b0;
                    n_touch = 1'b0;
                    // slot read issued now, data ready in S_READ
                    rd_addr = cmd_addr;
                    if (i_cmd.operation == wtse_pkg::OP_ALLOC) begin
                        n_ptr = (AW+1)'(1);
                        n_fsm = wtse_pkg::S_ALLOC;
                        n_first = 1'b1;
                    end else begin
                        n_ptr = (AW+1)'(cmd_addr);
                        n_fsm = wtse_pkg::S_READ;
                    end
                end
            end
            wtse_pkg::S_READ: begin
                // r_rd now holds the slot (issued last cycle)
                n_fsm = wtse_pkg::S_DONE;
                n_blk = BW'(id_blk8);
                if (r_cmd.operation > wtse_pkg::OP_TRY_WAIT || !id_ok) begin
                    n_st = wtse_pkg::RC_PARAM;
                end else begin
                    n_touch = 1'b1;
                    wr_addr = id_addr;
                    wr_data = r_rd;
                    unique case (r_cmd.operation)
                        wtse_pkg::OP_ADD_END: begin
                            if (rd_st != wtse_pkg::ST_ADDING) n_st = wtse_pkg::RC_STATE;
                            else begin
                                wr_en = 1'b1;
                                wr_data[3:0] = r_cmd.cancel ? wtse_pkg::ST_FREE
                                                            : wtse_pkg::ST_FINISHED;
                            end
                        end
                        wtse_pkg::OP_REM_BEGIN: begin
                            if (rd_st != wtse_pkg::ST_FINISHED) n_st = wtse_pkg::RC_STATE;
                            else begin
                                wr_en = 1'b1; wr_data[3:0] = wtse_pkg::ST_REMOVING;
                            end
                        end
                        wtse_pkg::OP_REM_END: begin
                            if (rd_st != wtse_pkg::ST_REMOVING) n_st = wtse_pkg::RC_STATE;
                            else begin
                                wr_en = 1'b1;
                                wr_data[3:0] = r_cmd.cancel ? wtse_pkg::ST_FINISHED
                                                            : wtse_pkg::ST_FREE;
                            end
                        end
                        wtse_pkg::OP_SCHED_BEGIN: begin
                            if (rd_st != wtse_pkg::ST_FINISHED) n_st = wtse_pkg::RC_STATE;
                            else begin
                                wr_en = 1'b1;
                                wr_data = {1'b0, r_cmd.priority_req,
                                           wtse_pkg::ST_SCHEDULING};
                            end
                        end
                        wtse_pkg::OP_SCHED_END: begin
                            if (rd_st != wtse_pkg::ST_SCHEDULING) n_st = wtse_pkg::RC_STATE;
                            else begin
                                wr_en = 1'b1;
                                wr_data[3:0] = r_cmd.cancel ? wtse_pkg::ST_FINISHED
                                                            : wtse_pkg::ST_READY;
                                if (!r_cmd.cancel) n_fsm = wtse_pkg::S_SCAN;
                            end
                        end
                        wtse_pkg::OP_UNSCHED_BEGIN: begin
                            if (rd_st == wtse_pkg::ST_READY || rd_st == wtse_pkg::ST_RUNNING
                                || rd_st == wtse_pkg::ST_WAITING) begin
                                wr_en = 1'b1; wr_data[3:0] = wtse_pkg::ST_UNSCHEDULING;
                            end else n_st = wtse_pkg::RC_STATE;
                        end
                        wtse_pkg::OP_UNSCHED_END: begin
                            if (rd_st != wtse_pkg::ST_UNSCHEDULING) n_st = wtse_pkg::RC_STATE;
                            else begin
                                wr_en = 1'b1; wr_data[3:0] = wtse_pkg::ST_FINISHED;
                                n_fsm = wtse_pkg::S_SCAN;
                            end
                        end
                        wtse_pkg::OP_SIGNAL: begin
                            if (rd_st == wtse_pkg::ST_FREE) n_st = wtse_pkg::RC_STATE;
                            else begin
                                wr_en = 1'b1; wr_data[12] = 1'b1;
                                n_fsm = wtse_pkg::S_SCAN;
                            end
                        end
                        wtse_pkg::OP_QUERY: begin
                            unique case (r_cmd.query_kind)
                                wtse_pkg::QK_INIT:     n_ans = rd_st != wtse_pkg::ST_FREE;
                                wtse_pkg::QK_READY:    n_ans = rd_st == wtse_pkg::ST_READY;
                                wtse_pkg::QK_WAITING:  n_ans = rd_st == wtse_pkg::ST_WAITING;
                                wtse_pkg::QK_RUNNING:  n_ans = rd_st == wtse_pkg::ST_RUNNING;
                                wtse_pkg::QK_FINISHED: n_ans = rd_st == wtse_pkg::ST_FINISHED;
                                wtse_pkg::QK_SIGNAL:   n_ans = r_rd[12];
                                default:               n_ans = 1'b0;
                            endcase
                        end
                        default: begin
                            if (rd_st == wtse_pkg::ST_FINISHED) n_st = wtse_pkg::RC_OK;
                            else if (rd_st == wtse_pkg::ST_FREE) n_st = wtse_pkg::RC_STATE;
                            else n_st = wtse_pkg::RC_BUSY;
                        end
                    endcase
                end
                if (n_fsm == wtse_pkg::S_SCAN) begin
                    n_ptr = (AW+1)'({BW'(id_blk8), {SW{1'b0}}}) + 1'b1;
                    n_scan_rdy = 1'b0; n_scan_wt = 1'b0; n_scan_top = '0;
                    n_first = 1'b1;
                end
            end
            wtse_pkg::S_ALLOC: begin
                // address r_lag has its data in r_rd unless first cycle
                rd_addr = r_ptr[AW-1:0];
                n_ptr = r_ptr + 1'b1;
                // last slot of a block: skip to slot 1 of the next block
                if (r_ptr[SW-1:0] == SW'(SLOTS_PER_BLOCK - 1))
                    n_ptr = r_ptr + (AW+1)'((1 << SW) - SLOTS_PER_BLOCK + 2);
                if (!r_first && rd_st == wtse_pkg::ST_FREE) begin
                    wr_en = 1'b1;
                    wr_addr = r_lag[AW-1:0];
                    wr_data = r_rd;
                    wr_data[3:0] = wtse_pkg::ST_ADDING;
                    n_given = 8'(int'(r_lag >> SW) * SLOTS_PER_BLOCK
                                 + int'(r_lag[SW-1:0]));
                    n_blk = BW'(r_lag >> SW);
                    n_touch = 1'b1;
                    n_fsm = wtse_pkg::S_DONE;
                end else if (!r_first && r_lag[AW-1:0] == LAST_ADDR) begin
                    n_st = wtse_pkg::RC_LIMIT;
                    n_fsm = wtse_pkg::S_DONE;
                end
            end
            wtse_pkg::S_SCAN: begin
                rd_addr = r_ptr[AW-1:0];
                n_ptr = r_ptr + 1'b1;
                if (!r_first) begin
                    if (rd_st == wtse_pkg::ST_READY) begin
                        n_scan_rdy = 1'b1;
                        if (r_rd[11:4] > r_scan_top) n_scan_top = r_rd[11:4];
                    end else if (rd_st == wtse_pkg::ST_WAITING) begin
                        n_scan_wt = 1'b1;
                    end
                    if (r_lag == scan_last) begin
                        n_rdy[r_blk] = n_scan_rdy;
                        n_wt[r_blk]  = n_scan_wt;
                        top_we = 1'b1;
                        n_top_w = n_scan_top;
                        n_acc = r_acc + 32'd1;
                        n_fsm = wtse_pkg::S_DONE;
                    end
                end
            end
            wtse_pkg::S_DONE: begin
                n_done = 1'b1;
                n_fsm = wtse_pkg::S_IDLE;
            end
            default: n_fsm = wtse_pkg::S_IDLE;
        endcase
    end

    assign busy   = r_clr || (r_fsm != wtse_pkg::S_IDLE);
    assign o_done = r_done;
    always_comb begin
        o_result = '0;
        o_result.status       = r_st;
        o_result.given_id     = r_given;
        o_result.query_answer = r_ans;
        o_result.access_count = r_acc;
        if (r_touch) begin
            o_result.blk_ready          = r_rdy[r_blk];
            o_result.blk_waiting        = r_wt[r_blk];
            o_result.block_top_priority = r_top[r_blk];
        end
    end

`ifndef NO_ASSERTIONS
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("done held two cycles");
    a_busy_no_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy) else $error("done while busy");
    a_acc_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acc != $past(r_acc) |-> r_acc == $past(r_acc) + 32'd1)
        else $error("access count jumped");
    a_limit_no_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.status == wtse_pkg::RC_LIMIT |-> o_result.given_id == 8'd0)
        else $error("limit with id");
`endif
endmodule
